/* rtl/p345_pkg.sv */
`timescale 1ns / 1ps

package p345_pkg;

    // Field and datapath widths.
    localparam int XW    = 32;          // abscissa, height and result fields
    localparam int WW    = 31;          // width register
    localparam int STEPS = 32;          // quotient bits per division
    localparam int SW    = 40;          // signed shape value
    localparam int MAGW  = 39;          // shape magnitude
    localparam int MW    = 71;          // |height| * |shape|
    localparam int W2W   = 62;          // width squared
    localparam int W3W   = 93;          // width cubed
    localparam int NVW   = 73;          // velocity numerator
    localparam int NAW   = 73;          // acceleration numerator
    localparam int NJW   = 94;          // jerk numerator
    localparam int RVW   = 48;          // velocity divisor and remainder
    localparam int RAW   = 63;          // acceleration divisor and remainder
    localparam int RJW   = 94;          // jerk divisor and remainder

    // Edges from the one that takes an item to the one that takes its result.
    localparam int RESULT_LAT = 76;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_ZERO = 2'd0;     // abscissa at or below zero
    localparam t_mode MODE_FULL = 2'd1;     // abscissa at or beyond the width
    localparam t_mode MODE_RISE = 2'd2;     // inside the rise

    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_WIDTH  = 1'b1;

    localparam logic [XW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [XW-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [XW-1:0] HEIGHT_RESET = 32'h0001_0000;
    localparam logic [WW-1:0] WIDTH_RESET  = 31'h0001_0000;

    // Applies the sign to a rounded magnitude and clamps it to the Q16.16 range.
    function automatic logic [XW-1:0] sat_out(input logic ovf, input logic [XW-1:0] q,
                                              input logic neg);
        logic big;
        big = ovf || q[XW-1];
        if (neg) begin
            return big ? SAT_MIN : (~q + 32'd1);
        end
        return big ? SAT_MAX : q;
    endfunction

endpackage

/* rtl/poly345_motion_profile_top.sv */
`timescale 1ns / 1ps

// 3-4-5 polynomial rise profile evaluator.
//
// Raise start for one cycle with the abscissa on i_abscissa; the item is taken at
// that edge when busy is low. Busy is high only for the first cycle after reset,
// so an item can be taken at every edge after that. Each item gives one result:
// o_valid is high for exactly one cycle with position, velocity, acceleration and
// jerk on their ports, all signed Q16.16 and saturated. The receiver cannot stall,
// so results must be taken as they appear.
// Throughput is one item per clock; it is set by the two 32-step restoring
// dividers (abscissa over width, then the three derivative scalings), each laid
// out as one quotient bit per pipeline stage.
// Height (index 0) and width (index 1) are written through i_cfg_we, i_cfg_idx and
// i_cfg_data while no item is in flight; the user is bound to this, the block
// itself does not enforce it. Width squared and cubed are rebuilt from the width
// register after a write, through r_w2, then r_w3lo and r_w3hi, then r_w3.
// Synchronous reset empties the pipeline and sets height and width to 1.0.

module poly345_motion_profile_top
    import p345_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [XW-1:0] i_abscissa,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [XW-1:0]        i_cfg_data,
    output logic                 o_valid,
    output logic signed [XW-1:0] o_position,
    output logic signed [XW-1:0] o_velocity,
    output logic signed [XW-1:0] o_acceleration,
    output logic signed [XW-1:0] o_jerk
);

    // Configuration and derived divisors.
    logic signed [XW-1:0] r_height;
    logic [WW-1:0]        r_width;
    logic [W2W-1:0]       r_w2;
    logic [W2W-1:0]       r_w3lo;
    logic [W2W-1:0]       r_w3hi;
    logic [W3W-1:0]       r_w3;
    logic                 r_busy;
    logic                 w_accept;

    // Stage group 1: a = x * 2^32 / width, one quotient bit per stage.
    logic           r_d1_vld  [0:STEPS];
    t_mode          r_d1_mode [0:STEPS];
    logic [WW-1:0]  r_d1_rem  [0:STEPS];
    logic [XW-1:0]  r_d1_q    [0:STEPS];
    logic [WW-1:0]  n_d1_rem  [0:STEPS-1];
    logic [XW-1:0]  n_d1_q    [0:STEPS-1];
    t_mode          w_mode_in;

    // Powers of a.
    logic           r_pw1_vld, r_pw2_vld, r_pw3_vld, r_pw4_vld;
    t_mode          r_pw1_mode, r_pw2_mode, r_pw3_mode, r_pw4_mode;
    logic [XW-1:0]  r_pw1_a, r_pw1_a2;
    logic [XW-1:0]  r_pw2_a, r_pw2_a2, r_pw2_a3;
    logic [XW-1:0]  r_pw3_a, r_pw3_a2, r_pw3_a3, r_pw3_a4;
    logic [XW-1:0]  r_pw4_a, r_pw4_a2, r_pw4_a3, r_pw4_a4, r_pw4_a5;
    logic [63:0]    w_sq1, w_sq2, w_sq3, w_sq4;

    // Shapes (index 0 position, 1 velocity, 2 acceleration, 3 jerk).
    logic           r_sh_vld;
    t_mode          r_sh_mode;
    logic [SW-1:0]  r_sh_s [0:3];
    logic [SW-1:0]  w_s    [0:3];
    logic [43:0]    w_sp44, w_sv44, w_sa44, w_sj44;

    logic            r_ab_vld;
    t_mode           r_ab_mode;
    logic [XW-1:0]   r_ab_hm;
    logic [MAGW-1:0] r_ab_mag [0:3];
    logic [3:0]      r_ab_neg;
    logic [MAGW-1:0] w_mag    [0:3];
    logic [3:0]      w_neg;
    logic [XW-1:0]   w_hm;

    // Product |height| * |shape| in two halves.
    logic           r_p1_vld;
    t_mode          r_p1_mode;
    logic [3:0]     r_p1_neg;
    logic [51:0]    r_p1_lo [0:3];
    logic [50:0]    r_p1_hi [0:3];

    logic           r_p2_vld;
    t_mode          r_p2_mode;
    logic [3:0]     r_p2_neg;
    logic [MW-1:0]  r_p2_m [0:3];

    // Rounded numerators.
    logic           r_n_vld;
    t_mode          r_n_mode;
    logic [2:0]     r_n_neg;
    logic [XW-1:0]  r_n_pos;
    logic [NVW-1:0] r_n_nv;
    logic [NAW-1:0] r_n_na;
    logic [NJW-1:0] r_n_nj;
    logic [71:0]    w_psum;
    logic [39:0]    w_pq;

    // Stage group 2: derivative scalings, three dividers side by side.
    // Each low register first holds the numerator bits still to be shifted in
    // and fills with quotient bits from the right.
    logic           r_d2_vld  [0:STEPS];
    t_mode          r_d2_mode [0:STEPS];
    logic [2:0]     r_d2_neg  [0:STEPS];
    logic [2:0]     r_d2_ovf  [0:STEPS];
    logic [XW-1:0]  r_d2_pos  [0:STEPS];
    logic [RVW-1:0] r_d2_vr   [0:STEPS];
    logic [XW-1:0]  r_d2_vq   [0:STEPS];
    logic [RAW-1:0] r_d2_ar   [0:STEPS];
    logic [XW-1:0]  r_d2_aq   [0:STEPS];
    logic [RJW-1:0] r_d2_jr   [0:STEPS];
    logic [XW-1:0]  r_d2_jq   [0:STEPS];
    logic [RVW-1:0] n_d2_vr   [0:STEPS-1];
    logic [XW-1:0]  n_d2_vq   [0:STEPS-1];
    logic [RAW-1:0] n_d2_ar   [0:STEPS-1];
    logic [XW-1:0]  n_d2_aq   [0:STEPS-1];
    logic [RJW-1:0] n_d2_jr   [0:STEPS-1];
    logic [XW-1:0]  n_d2_jq   [0:STEPS-1];
    logic [RVW-1:0] w_dv, w_vhi;
    logic [RAW-1:0] w_da, w_ahi;
    logic [RJW-1:0] w_dj, w_jhi;

    // Result register.
    logic           r_out_vld;
    t_mode          r_out_mode;
    logic [XW-1:0]  r_out_pos, r_out_vel, r_out_acc, r_out_jrk;
    logic [XW-1:0]  n_out_pos, n_out_vel, n_out_acc, n_out_jrk;

    assign w_accept = start && !r_busy;

    // Divisors.
    assign w_dv = {r_width, 17'd0};
    assign w_da = {r_w2, 1'b0};
    assign w_dj = {r_w3, 1'b0};

    always_comb begin
        if (i_abscissa[XW-1] || i_abscissa == 32'sd0) begin
            w_mode_in = MODE_ZERO;
        end else if (i_abscissa[WW-1:0] >= r_width) begin
            w_mode_in = MODE_FULL;
        end else begin
            w_mode_in = MODE_RISE;
        end
    end

    // Remainder stays below the width, so the doubled value fits 32 bits and the
    // bits shifted in are all zero.
    always_comb begin
        logic [XW-1:0] rem2;
        logic          ge;
        rem2 = '0;
        ge   = 1'b0;
        for (int i = 0; i < STEPS; i++) begin
            rem2        = {r_d1_rem[i], 1'b0};
            ge          = rem2 >= {1'b0, r_width};
            n_d1_rem[i] = ge ? WW'(rem2 - {1'b0, r_width}) : rem2[WW-1:0];
            n_d1_q[i]   = {r_d1_q[i][XW-2:0], ge};
        end
    end

    assign w_sq1 = 64'(r_d1_q[STEPS]) * 64'(r_d1_q[STEPS]);
    assign w_sq2 = 64'(r_pw1_a2) * 64'(r_pw1_a);
    assign w_sq3 = 64'(r_pw2_a3) * 64'(r_pw2_a);
    assign w_sq4 = 64'(r_pw3_a4) * 64'(r_pw3_a);

    // Shape polynomials in signed Q8.32; the constant multiplies reduce to shift-adds.
    always_comb begin
        w_sp44 = 44'(r_pw4_a3) * 44'd10 - 44'(r_pw4_a4) * 44'd15 + 44'(r_pw4_a5) * 44'd6;
        w_sv44 = 44'(r_pw4_a2) * 44'd30 - 44'(r_pw4_a3) * 44'd60 + 44'(r_pw4_a4) * 44'd30;
        w_sa44 = 44'(r_pw4_a) * 44'd60 - 44'(r_pw4_a2) * 44'd180 + 44'(r_pw4_a3) * 44'd120;
        w_sj44 = (44'd60 << 32) - 44'(r_pw4_a) * 44'd360 + 44'(r_pw4_a2) * 44'd360;
        w_s[0] = w_sp44[SW-1:0];
        w_s[1] = w_sv44[SW-1:0];
        w_s[2] = w_sa44[SW-1:0];
        w_s[3] = w_sj44[SW-1:0];
    end

    always_comb begin
        w_hm = r_height[XW-1] ? 32'(~r_height + 32'sd1) : 32'(r_height);
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = r_sh_s[i][SW-1] ? MAGW'(~r_sh_s[i] + 40'd1) : r_sh_s[i][MAGW-1:0];
            w_neg[i] = r_height[XW-1] ^ r_sh_s[i][SW-1];
        end
    end

    // Position divides by 2^32: rounding is an add and a shift.
    assign w_psum = 72'(r_p2_m[0]) + 72'h0_8000_0000;
    assign w_pq   = w_psum[71:32];

    assign w_vhi = RVW'(r_n_nv[NVW-1:32]);
    assign w_ahi = RAW'(r_n_na[NAW-1:32]);
    assign w_jhi = RJW'(r_n_nj[NJW-1:32]);

    always_comb begin
        logic [RVW:0] vr2;
        logic [RAW:0] ar2;
        logic [RJW:0] jr2;
        logic         vge, age, jge;
        vr2 = '0;
        ar2 = '0;
        jr2 = '0;
        vge = 1'b0;
        age = 1'b0;
        jge = 1'b0;
        for (int i = 0; i < STEPS; i++) begin
            vr2 = {r_d2_vr[i], r_d2_vq[i][XW-1]};
            ar2 = {r_d2_ar[i], r_d2_aq[i][XW-1]};
            jr2 = {r_d2_jr[i], r_d2_jq[i][XW-1]};
            vge = vr2 >= {1'b0, w_dv};
            age = ar2 >= {1'b0, w_da};
            jge = jr2 >= {1'b0, w_dj};
            n_d2_vr[i] = vge ? RVW'(vr2 - {1'b0, w_dv}) : vr2[RVW-1:0];
            n_d2_ar[i] = age ? RAW'(ar2 - {1'b0, w_da}) : ar2[RAW-1:0];
            n_d2_jr[i] = jge ? RJW'(jr2 - {1'b0, w_dj}) : jr2[RJW-1:0];
            n_d2_vq[i] = {r_d2_vq[i][XW-2:0], vge};
            n_d2_aq[i] = {r_d2_aq[i][XW-2:0], age};
            n_d2_jq[i] = {r_d2_jq[i][XW-2:0], jge};
        end
    end

    always_comb begin
        n_out_vel = '0;
        n_out_acc = '0;
        n_out_jrk = '0;
        case (r_d2_mode[STEPS])
            MODE_RISE: begin
                n_out_pos = r_d2_pos[STEPS];
                n_out_vel = sat_out(r_d2_ovf[STEPS][0], r_d2_vq[STEPS], r_d2_neg[STEPS][0]);
                n_out_acc = sat_out(r_d2_ovf[STEPS][1], r_d2_aq[STEPS], r_d2_neg[STEPS][1]);
                n_out_jrk = sat_out(r_d2_ovf[STEPS][2], r_d2_jq[STEPS], r_d2_neg[STEPS][2]);
            end
            MODE_FULL: begin
                n_out_pos = r_height;
            end
            default: begin
                n_out_pos = '0;
            end
        endcase
    end

    // Control state: configuration, busy and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_height <= HEIGHT_RESET;
            r_width  <= WIDTH_RESET;
            for (int i = 0; i <= STEPS; i++) begin
                r_d1_vld[i] <= 1'b0;
                r_d2_vld[i] <= 1'b0;
            end
            r_pw1_vld <= 1'b0;
            r_pw2_vld <= 1'b0;
            r_pw3_vld <= 1'b0;
            r_pw4_vld <= 1'b0;
            r_sh_vld  <= 1'b0;
            r_ab_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_n_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_WIDTH:  r_width  <= i_cfg_data[WW-1:0];
                    default: begin
                    end
                endcase
            end
            r_d1_vld[0] <= w_accept;
            for (int i = 0; i < STEPS; i++) begin
                r_d1_vld[i+1] <= r_d1_vld[i];
                r_d2_vld[i+1] <= r_d2_vld[i];
            end
            r_pw1_vld   <= r_d1_vld[STEPS];
            r_pw2_vld   <= r_pw1_vld;
            r_pw3_vld   <= r_pw2_vld;
            r_pw4_vld   <= r_pw3_vld;
            r_sh_vld    <= r_pw4_vld;
            r_ab_vld    <= r_sh_vld;
            r_p1_vld    <= r_ab_vld;
            r_p2_vld    <= r_p1_vld;
            r_n_vld     <= r_p2_vld;
            r_d2_vld[0] <= r_n_vld;
            r_out_vld   <= r_d2_vld[STEPS];
        end
    end

    // Datapath registers; the valid bits above say which of them hold an item.
    always_ff @(posedge i_clk) begin
        r_w2   <= W2W'(r_width) * W2W'(r_width);
        r_w3lo <= W2W'(r_w2[30:0]) * W2W'(r_width);
        r_w3hi <= W2W'(r_w2[W2W-1:31]) * W2W'(r_width);
        r_w3   <= W3W'(r_w3lo) + (W3W'(r_w3hi) << 31);

        r_d1_mode[0] <= w_mode_in;
        r_d1_rem[0]  <= i_abscissa[WW-1:0];
        r_d1_q[0]    <= '0;
        for (int i = 0; i < STEPS; i++) begin
            r_d1_mode[i+1] <= r_d1_mode[i];
            r_d1_rem[i+1]  <= n_d1_rem[i];
            r_d1_q[i+1]    <= n_d1_q[i];
        end

        r_pw1_mode <= r_d1_mode[STEPS];
        r_pw1_a    <= r_d1_q[STEPS];
        r_pw1_a2   <= w_sq1[63:32];

        r_pw2_mode <= r_pw1_mode;
        r_pw2_a    <= r_pw1_a;
        r_pw2_a2   <= r_pw1_a2;
        r_pw2_a3   <= w_sq2[63:32];

        r_pw3_mode <= r_pw2_mode;
        r_pw3_a    <= r_pw2_a;
        r_pw3_a2   <= r_pw2_a2;
        r_pw3_a3   <= r_pw2_a3;
        r_pw3_a4   <= w_sq3[63:32];

        r_pw4_mode <= r_pw3_mode;
        r_pw4_a    <= r_pw3_a;
        r_pw4_a2   <= r_pw3_a2;
        r_pw4_a3   <= r_pw3_a3;
        r_pw4_a4   <= r_pw3_a4;
        r_pw4_a5   <= w_sq4[63:32];

        r_sh_mode <= r_pw4_mode;
        r_ab_mode <= r_sh_mode;
        r_ab_hm   <= w_hm;
        r_ab_neg  <= w_neg;
        r_p1_mode <= r_ab_mode;
        r_p1_neg  <= r_ab_neg;
        r_p2_mode <= r_p1_mode;
        r_p2_neg  <= r_p1_neg;
        for (int i = 0; i < 4; i++) begin
            r_sh_s[i]   <= w_s[i];
            r_ab_mag[i] <= w_mag[i];
            r_p1_lo[i]  <= 52'(r_ab_hm) * 52'(r_ab_mag[i][19:0]);
            r_p1_hi[i]  <= 51'(r_ab_hm) * 51'(r_ab_mag[i][MAGW-1:20]);
            r_p2_m[i]   <= MW'(r_p1_lo[i]) + (MW'(r_p1_hi[i]) << 20);
        end

        // Numerators 2N + D for rounding to nearest, ties away from zero.
        r_n_mode <= r_p2_mode;
        r_n_neg  <= r_p2_neg[3:1];
        r_n_pos  <= sat_out(|w_pq[39:32], w_pq[31:0], r_p2_neg[0]);
        r_n_nv   <= (NVW'(r_p2_m[1]) << 1) + NVW'({r_width, 16'd0});
        r_n_na   <= (NAW'(r_p2_m[2]) << 1) + NAW'(r_w2);
        r_n_nj   <= (NJW'(r_p2_m[3]) << 17) + NJW'(r_w3);

        // A quotient of 2^32 or more is flagged here and saturates at the end.
        r_d2_mode[0] <= r_n_mode;
        r_d2_neg[0]  <= r_n_neg;
        r_d2_pos[0]  <= r_n_pos;
        r_d2_ovf[0]  <= {w_jhi >= w_dj, w_ahi >= w_da, w_vhi >= w_dv};
        r_d2_vr[0]   <= w_vhi;
        r_d2_vq[0]   <= r_n_nv[XW-1:0];
        r_d2_ar[0]   <= w_ahi;
        r_d2_aq[0]   <= r_n_na[XW-1:0];
        r_d2_jr[0]   <= w_jhi;
        r_d2_jq[0]   <= r_n_nj[XW-1:0];
        for (int i = 0; i < STEPS; i++) begin
            r_d2_mode[i+1] <= r_d2_mode[i];
            r_d2_neg[i+1]  <= r_d2_neg[i];
            r_d2_ovf[i+1]  <= r_d2_ovf[i];
            r_d2_pos[i+1]  <= r_d2_pos[i];
            r_d2_vr[i+1]   <= n_d2_vr[i];
            r_d2_vq[i+1]   <= n_d2_vq[i];
            r_d2_ar[i+1]   <= n_d2_ar[i];
            r_d2_aq[i+1]   <= n_d2_aq[i];
            r_d2_jr[i+1]   <= n_d2_jr[i];
            r_d2_jq[i+1]   <= n_d2_jq[i];
        end

        r_out_mode <= r_d2_mode[STEPS];
        r_out_pos  <= n_out_pos;
        r_out_vel  <= n_out_vel;
        r_out_acc  <= n_out_acc;
        r_out_jrk  <= n_out_jrk;
    end

    assign busy           = r_busy;
    assign o_valid        = r_out_vld;
    assign o_position     = r_out_pos;
    assign o_velocity     = r_out_vel;
    assign o_acceleration = r_out_acc;
    assign o_jerk         = r_out_jrk;

    // Every result belongs to an item taken a fixed number of edges earlier.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, RESULT_LAT))
        else $error("result without a matching item");

    // At or beyond the width the profile rests at the configured height.
    a_full_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_mode == MODE_FULL) |->
        (o_position == $past(r_height) && o_velocity == '0 &&
         o_acceleration == '0 && o_jerk == '0))
        else $error("full-rise item gave wrong result");

    // At or before the origin everything is zero.
    a_zero_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_mode == MODE_ZERO) |->
        (o_position == '0 && o_velocity == '0 && o_acceleration == '0 && o_jerk == '0))
        else $error("item before the origin gave a nonzero result");

endmodule

/* test/tb_poly345_motion_profile_top.sv */
`timescale 1ns / 1ps

module tb_poly345_motion_profile_top;
    import p345_pkg::*;

    typedef struct packed {
        logic [XW-1:0] pos;
        logic [XW-1:0] vel;
        logic [XW-1:0] acc;
        logic [XW-1:0] jrk;
    } t_profile;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic          idx;
        logic [XW-1:0] value;
        logic          typed;
        t_profile      res;
    } t_row;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [XW-1:0] i_abscissa;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [XW-1:0]        i_cfg_data;
    logic                 o_valid;
    logic signed [XW-1:0] o_position;
    logic signed [XW-1:0] o_velocity;
    logic signed [XW-1:0] o_acceleration;
    logic signed [XW-1:0] o_jerk;

    // Sideband for directed rows whose result is written out by hand.
    logic     typed_now;
    t_profile typed_res;

    logic signed [XW-1:0] height_reg;
    logic [WW-1:0]        width_reg;
    t_profile             pending[$];
    int                   errors   = 0;
    int                   accepted = 0;
    int                   checked  = 0;
    int                   cycles   = 0;

    poly345_motion_profile_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_abscissa     (i_abscissa),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_jerk         (o_jerk)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Rounds height * shape * 2^k / den to nearest, ties away from zero, then clamps.
    function automatic logic [XW-1:0] scale_round(input logic signed [XW-1:0] h,
                                                  input longint s, input int k,
                                                  input logic [127:0] den);
        logic         neg;
        logic [63:0]  hm;
        logic [63:0]  sm;
        logic [127:0] num;
        logic [127:0] q;
        neg = (h < 0) != (s < 0);
        hm  = (h < 0) ? 64'd0 - 64'(longint'(h)) : 64'(longint'(h));
        sm  = (s < 0) ? 64'd0 - 64'(s) : 64'(s);
        num = 128'(hm) * 128'(sm);
        num = num << k;
        num = (num << 1) + den;
        q   = num / (den << 1);
        if (neg) begin
            if (q >= 128'h8000_0000)
                return SAT_MIN;
            return ~q[XW-1:0] + 32'd1;
        end
        if (q > 128'h7FFF_FFFF)
            return SAT_MAX;
        return q[XW-1:0];
    endfunction

    function automatic t_profile profile_at(input logic signed [XW-1:0] x,
                                            input logic signed [XW-1:0] h,
                                            input logic [WW-1:0] w);
        t_profile     r;
        logic [63:0]  a;
        logic [63:0]  a2;
        logic [63:0]  a3;
        logic [63:0]  a4;
        logic [63:0]  a5;
        longint       sp;
        longint       sv;
        longint       sa;
        longint       sj;
        logic [127:0] wsq;
        r = '0;
        if (x <= 0)
            return r;
        if (x >= $signed({1'b0, w})) begin
            r.pos = h;
            return r;
        end
        // Normalized abscissa in Q0.32; each higher power is truncated on its own.
        a  = {x, 32'd0} / 64'(w);
        a2 = (a * a) >> 32;
        a3 = (a2 * a) >> 32;
        a4 = (a3 * a) >> 32;
        a5 = (a4 * a) >> 32;
        sp = 10 * $signed(a3) - 15 * $signed(a4) + 6 * $signed(a5);
        sv = 30 * $signed(a2) - 60 * $signed(a3) + 30 * $signed(a4);
        sa = 60 * $signed(a) - 180 * $signed(a2) + 120 * $signed(a3);
        sj = 60 * (longint'(1) << 32) - 360 * $signed(a) + 360 * $signed(a2);
        wsq   = 128'(w) * 128'(w);
        r.pos = scale_round(h, sp, 0, 128'h1_0000_0000);
        r.vel = scale_round(h, sv, 0, 128'(w) << 16);
        r.acc = scale_round(h, sa, 0, wsq);
        r.jrk = scale_round(h, sj, 16, wsq * 128'(w));
        return r;
    endfunction

    task automatic check_field(input string name, input logic [XW-1:0] want,
                               input logic [XW-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    // Results are retired before the item of the same edge is queued, so the order is fixed.
    always @(posedge i_clk) begin
        t_profile want;
        if (!i_rst_n) begin
            height_reg = HEIGHT_RESET;
            width_reg  = WIDTH_RESET;
        end else begin
            if (o_valid) begin
                if (pending.size() == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = pending.pop_front();
                    checked++;
                    check_field("position", want.pos, o_position);
                    check_field("velocity", want.vel, o_velocity);
                    check_field("acceleration", want.acc, o_acceleration);
                    check_field("jerk", want.jrk, o_jerk);
                end
            end
            if (start && !busy) begin
                pending.push_back(typed_now ? typed_res
                                            : profile_at(i_abscissa, height_reg, width_reg));
                accepted++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEIGHT)
                    height_reg = i_cfg_data;
                else
                    width_reg = i_cfg_data[WW-1:0];
            end
        end
    end

    task automatic send_item(input logic [XW-1:0] x, input logic typed, input t_profile res);
        @(negedge i_clk);
        start      <= 1'b1;
        i_abscissa <= x;
        typed_now  <= typed;
        typed_res  <= res;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        while (pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [XW-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row item_row(input logic [XW-1:0] x);
        return '{ROW_ITEM, CFG_HEIGHT, x, 1'b0, '0};
    endfunction

    // Only the flat parts of the profile are typed in: position alone, derivatives zero.
    function automatic t_row typed_row(input logic [XW-1:0] x, input logic [XW-1:0] pos);
        return '{ROW_ITEM, CFG_HEIGHT, x, 1'b1, '{pos, 32'd0, 32'd0, 32'd0}};
    endfunction

    function automatic t_row cfg_row(input logic idx, input logic [XW-1:0] value);
        return '{ROW_CFG, idx, value, 1'b0, '0};
    endfunction

    function automatic logic [XW-1:0] pick_height();
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return $urandom_range(32'h3_FFFF, 0) - 32'h2_0000;
            2: return $urandom_range(1, 0) ? SAT_MAX : SAT_MIN;
            default: return $urandom_range(32'h0010_0000, 32'h0000_1000);
        endcase
    endfunction

    function automatic logic [WW-1:0] pick_width();
        case ($urandom_range(3, 0))
            0: return WW'($urandom_range(16, 1));
            1: return WW'($urandom_range(32'h0010_0000, 32'h0000_0400));
            2: return WW'($urandom_range(32'h7FFF_FFFF, 1));
            default: return 31'h7FFF_FFFF - WW'($urandom_range(255, 0));
        endcase
    endfunction

    // Mostly points inside the rise; the rest are the flat regions and the borders.
    function automatic logic [XW-1:0] pick_abscissa(input logic [WW-1:0] w);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70 && w > 1)
            return $urandom_range(w - 1, 1);
        if (r < 76 && w > 1)
            return $urandom_range(1, 0) ? 32'd1 : 32'(w - 1);
        if (r < 82)
            return $urandom;
        if (r < 88)
            return 32'(w) + $urandom_range(1, 0);
        if (r < 94)
            return 32'd0 - $urandom_range(32'h0001_0000, 0);
        return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    initial begin
        t_row          dir_rows[$];
        logic [WW-1:0] w;
        logic [XW-1:0] h;
        int            sent;
        int            burst;
        logic          no_gaps;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_abscissa = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_HEIGHT;
        i_cfg_data = '0;
        typed_now  = 1'b0;
        typed_res  = '0;

        // Reset values first, then the extremes of height and width.
        dir_rows.push_back(typed_row(32'h0000_0000, 32'h0000_0000));
        dir_rows.push_back(typed_row(32'h8000_0000, 32'h0000_0000));
        dir_rows.push_back(typed_row(32'h7FFF_FFFF, HEIGHT_RESET));
        dir_rows.push_back(typed_row(32'h0001_0000, HEIGHT_RESET));
        dir_rows.push_back(item_row(32'h0000_8000));
        dir_rows.push_back(item_row(32'h0000_0001));
        dir_rows.push_back(item_row(32'h0000_FFFF));
        dir_rows.push_back(cfg_row(CFG_HEIGHT, SAT_MIN));
        dir_rows.push_back(item_row(32'h0000_8000));
        dir_rows.push_back(typed_row(32'h7FFF_FFFF, SAT_MIN));
        dir_rows.push_back(cfg_row(CFG_HEIGHT, SAT_MAX));
        dir_rows.push_back(item_row(32'h0000_0064));
        dir_rows.push_back(cfg_row(CFG_WIDTH, 32'h0000_0001));
        dir_rows.push_back(typed_row(32'h0000_0001, SAT_MAX));
        dir_rows.push_back(cfg_row(CFG_WIDTH, 32'h0000_0002));
        dir_rows.push_back(item_row(32'h0000_0001));
        dir_rows.push_back(cfg_row(CFG_WIDTH, 32'h7FFF_FFFF));
        dir_rows.push_back(item_row(32'h3FFF_FFFF));
        dir_rows.push_back(item_row(32'h7FFF_FFFE));
        dir_rows.push_back(typed_row(32'h7FFF_FFFF, SAT_MAX));
        dir_rows.push_back(cfg_row(CFG_HEIGHT, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row(32'h00BC_614E));
        // The top data bit is not part of the width register.
        dir_rows.push_back(cfg_row(CFG_WIDTH, 32'h8000_0003));
        dir_rows.push_back(item_row(32'h0000_0001));
        dir_rows.push_back(item_row(32'h0000_0002));
        dir_rows.push_back(cfg_row(CFG_HEIGHT, 32'h0000_0000));
        dir_rows.push_back(item_row(32'h0000_0001));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_CFG) begin
                pause(1);
                drain();
                write_reg(dir_rows[n].idx, dir_rows[n].value);
            end else begin
                send_item(dir_rows[n].value, dir_rows[n].typed, dir_rows[n].res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin h = SAT_MAX; w = 31'h7FFF_FFFF; end
                1: begin h = SAT_MIN; w = 31'd1; end
                2: begin h = HEIGHT_RESET; w = WIDTH_RESET; end
                default: begin h = pick_height(); w = pick_width(); end
            endcase
            // The sender holds off here until the block has returned every result.
            pause(1);
            drain();
            write_reg(CFG_HEIGHT, h);
            write_reg(CFG_WIDTH, {1'($urandom_range(1, 0)), w});
            no_gaps = (p % 3 == 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(24, 1);
                if (burst > ITEMS_PER_PHASE - sent)
                    burst = ITEMS_PER_PHASE - sent;
                repeat (burst) begin
                    send_item(pick_abscissa(w), 1'b0, '0);
                    sent++;
                end
                if (!no_gaps)
                    pause($urandom_range(6, 1));
            end
        end

        pause(1);
        drain();
        repeat (RESULT_LAT + 8) @(posedge i_clk);

        $display("Checked %0d of %0d items over %0d register settings,", checked, accepted,
                 PHASES + 8);
        $display("covering flat regions, saturating derivatives and full-scale widths.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/p345_pkg.sv
rtl/poly345_motion_profile_top.sv
test/tb_poly345_motion_profile_top.sv
